@@ rtl/assert_macros.svh @@
// assertion helpers, used with clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCGR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcgr assertion failed");

// next-cycle implication
`define TCGR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcgr assertion failed");

`endif

@@ rtl/tcgr_pkg.sv @@
package tcgr_pkg;

    localparam int CELL_WIDTH           = 8;
    localparam int CELL_SHIFT           = 3;
    localparam int MAX_GLYPH_HEIGHT_DEF = 32;
    localparam int GLYPH_COUNT_DEF      = 256;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic [1:0] MODE_DRAW = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    localparam logic [2:0] REG_COLUMNS      = 3'd0;
    localparam logic [2:0] REG_ROWS         = 3'd1;
    localparam logic [2:0] REG_OFFSET_COL   = 3'd2;
    localparam logic [2:0] REG_OFFSET_ROW   = 3'd3;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd4;

    localparam logic [10:0] COLUMNS_RST      = 11'd80;
    localparam logic [10:0] ROWS_RST         = 11'd25;
    localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [9:0] cursor_col;
        logic [9:0] cursor_line;
        logic [4:0] glyph_row;
        logic [7:0] glyph_bits;
    } tcgr_in_t;

    typedef struct packed {
        logic [13:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  row_mask;
        logic        last_row;
    } tcgr_out_t;

endpackage

@@ rtl/tcgr_font_mem.sv @@
module tcgr_font_mem
    import tcgr_pkg::*;
#(
    parameter int ADDR_W = 13
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/text_cell_glyph_renderer_core.sv @@
// Text console character generator for 8-pixel-wide fonts. Set cursor and glyph-byte load
// transfers complete as they are accepted, and a newline then takes the cursor update step.
// A printable character passes through an accept step, a setup step in which the single
// multiplier forms the cell's pixel y, then h row reads at one per cycle when the receiver
// keeps up, through the font memory's one read port, where h is glyph_height saturated to
// MAX_GLYPH_HEIGHT, a step in which the row counter is seen complete, then a cursor update
// step. Each row read gives one result transfer; a receiver that holds off stalls the row
// reads and adds its hold time. The font memory is not cleared at reset; a glyph row that
// was never loaded reads as an unknown mask.
module text_cell_glyph_renderer_core
    import tcgr_pkg::*;
#(
    parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT      = GLYPH_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tcgr_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output tcgr_out_t out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

`include "assert_macros.svh"

    localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int RW = $clog2(MAX_GLYPH_HEIGHT);
    localparam int CW = $clog2(GLYPH_COUNT);
    localparam int AW = CW + RW;
    localparam logic [5:0]  MGH6 = 6'(MAX_GLYPH_HEIGHT);
    localparam logic [8:0]  GC9  = 9'(GLYPH_COUNT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_ROWS  = 2'd2;
    localparam logic [1:0] S_WRAP  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [9:0]    cur_col_reg, cur_col_next;
    logic [9:0]    cur_line_reg, cur_line_next;
    logic [10:0]   columns_reg, rows_reg;
    logic [9:0]    offset_col_reg, offset_row_reg;
    logic [5:0]    glyph_height_reg;
    logic          newline_reg, newline_next;
    logic          code_ok_reg, code_ok_next;
    logic [7:0]    code_reg, code_next;
    logic [HW-1:0] h_reg, h_next;
    logic [HW-1:0] row_cnt_reg, row_cnt_next;
    logic [13:0]   base_x_reg, base_x_next;
    logic [15:0]   base_y_reg, base_y_next;
    logic          pend_reg, pend_next;
    logic [15:0]   pend_y_reg, pend_y_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    tcgr_out_t     out_data_reg, out_data_next;

    logic          in_xfer;
    logic          load;
    logic          rd_en;
    logic          wr_en;
    logic [7:0]    rd_data;
    logic [HW-1:0] h_sat;
    logic [10:0]   col_sum, line_sum;
    logic [16:0]   prod;
    logic [10:0]   col_a, line_a, line_b;
    logic          col_wrap;

    assign in_ready  = (state_reg == S_IDLE) && !pend_reg;
    assign in_xfer   = in_valid && in_ready;
    assign load      = pend_reg && (!out_valid_reg || out_ready);
    assign rd_en     = (state_reg == S_ROWS) && (row_cnt_reg != h_reg) && (!pend_reg || load);
    assign wr_en     = in_xfer && (in_data.mode == MODE_LOAD)
                       && ({1'b0, in_data.char_code} < GC9)
                       && ({1'b0, in_data.glyph_row} < MGH6);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tcgr_font_mem #(
        .ADDR_W (AW)
    ) u_font (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({in_data.char_code[CW-1:0], in_data.glyph_row[RW-1:0]}),
        .wr_data (in_data.glyph_bits),
        .rd_en   (rd_en),
        .rd_addr ({code_reg[CW-1:0], row_cnt_reg[RW-1:0]}),
        .rd_data (rd_data)
    );

    always_comb
    begin
        h_sat    = (glyph_height_reg > MGH6) ? HW'(MAX_GLYPH_HEIGHT) : HW'(glyph_height_reg);
        col_sum  = 11'(cur_col_reg) + 11'(offset_col_reg);
        line_sum = 11'(cur_line_reg) + 11'(offset_row_reg);
        prod     = 17'(line_sum) * 17'(h_sat);
        col_a    = newline_reg ? 11'd0 : 11'(cur_col_reg) + 11'd1;
        line_a   = newline_reg ? 11'(cur_line_reg) + 11'd1 : 11'(cur_line_reg);
        col_wrap = col_a >= columns_reg;
        line_b   = col_wrap ? line_a + 11'd1 : line_a;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_line_next  = cur_line_reg;
        newline_next   = newline_reg;
        code_ok_next   = code_ok_reg;
        code_next      = code_reg;
        h_next         = h_reg;
        row_cnt_next   = row_cnt_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        pend_next      = pend_reg;
        pend_y_next    = pend_y_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.mode == MODE_SET)
                    begin
                        cur_col_next  = in_data.cursor_col;
                        cur_line_next = in_data.cursor_line;
                    end
                    else if (in_data.mode == MODE_DRAW)
                    begin
                        code_next    = in_data.char_code;
                        code_ok_next = {1'b0, in_data.char_code} < GC9;
                        newline_next = in_data.char_code == NEWLINE_CODE;
                        state_next   = (in_data.char_code == NEWLINE_CODE) ? S_WRAP : S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                h_next       = h_sat;
                row_cnt_next = '0;
                base_x_next  = {col_sum, {CELL_SHIFT{1'b0}}};
                base_y_next  = prod[15:0];
                state_next   = S_ROWS;
            end
            S_ROWS:
            begin
                if (row_cnt_reg == h_reg)
                begin
                    state_next = S_WRAP;
                end
                else if (rd_en)
                begin
                    pend_y_next    = base_y_reg + 16'(row_cnt_reg);
                    pend_last_next = HW'(row_cnt_reg + 1'b1) == h_reg;
                    row_cnt_next   = HW'(row_cnt_reg + 1'b1);
                end
            end
            S_WRAP:
            begin
                cur_col_next  = col_wrap ? 10'd0 : col_a[9:0];
                cur_line_next = (line_b >= rows_reg) ? 10'd0 : line_b[9:0];
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // row transfer pipeline: read in flight, then output register
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.pixel_x  = base_x_reg;
            out_data_next.pixel_y  = pend_y_reg;
            out_data_next.row_mask = code_ok_reg ? rd_data : 8'd0;
            out_data_next.last_row = pend_last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_en)
        begin
            pend_next = 1'b1;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= '0;
            cur_line_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            row_cnt_reg   <= '0;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_line_reg  <= cur_line_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            row_cnt_reg   <= row_cnt_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg      <= COLUMNS_RST;
            rows_reg         <= ROWS_RST;
            offset_col_reg   <= '0;
            offset_row_reg   <= '0;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLUMNS:      columns_reg      <= cfg_data;
                REG_ROWS:         rows_reg         <= cfg_data;
                REG_OFFSET_COL:   offset_col_reg   <= cfg_data[9:0];
                REG_OFFSET_ROW:   offset_row_reg   <= cfg_data[9:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        newline_reg   <= newline_next;
        code_ok_reg   <= code_ok_next;
        code_reg      <= code_next;
        base_x_reg    <= base_x_next;
        base_y_reg    <= base_y_next;
        pend_y_reg    <= pend_y_next;
        pend_last_reg <= pend_last_next;
        out_data_reg  <= out_data_next;
    end

    `TCGR_ASSERT_IMP(a_read_in_rows, rd_en, state_reg == S_ROWS)
    `TCGR_ASSERT_IMP(a_row_bound, state_reg == S_ROWS, row_cnt_reg <= h_reg)
    `TCGR_ASSERT_NEXT(a_pend_held, pend_reg && !load, pend_reg)
    `TCGR_ASSERT_NEXT(a_wrap_done, state_reg == S_WRAP, state_reg == S_IDLE)

endmodule
